FILE: rtl/eta_pkg.sv
// ----------------------------------------------------------------------------
// eta_pkg: shared types and constants of the envelope transient analyzer
// Payload structs, register indexes, widths and the control interface
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package eta_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int ENV_W       = 24;  // Q1.23 envelope
  localparam int COEF_W      = 24;  // Q0.24 coefficients
  localparam int FLOOR_W     = 16;
  localparam int SPS_W       = 18;
  localparam int SECS_W      = 16;
  localparam int OUT_W       = 16;
  localparam int TOTAL_W     = 20;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  // Divider: (tally << 24) / (10 * seconds)
  localparam int NUM_W       = COUNT_BITS + ENV_W;
  localparam int DIV_W       = SECS_W + 4;
  localparam int STEP_W      = $clog2(NUM_W + 1);

  // Register reset values
  localparam logic [COEF_W-1:0]  ATTACK_RST  = COEF_W'(16401071);
  localparam logic [COEF_W-1:0]  RELEASE_RST = COEF_W'(16773412);
  localparam logic [FLOOR_W-1:0] FLOOR_RST   = FLOOR_W'(3277);
  localparam logic [SPS_W-1:0]   SPS_RST     = SPS_W'(44100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_FLOOR   = 2'd2,
    CFG_SPS     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0]   punch;
    logic [OUT_W-1:0]   peak_level;
    logic [TOTAL_W-1:0] transient_total;
  } out_t;

  // Sequencer to datapath
  typedef struct packed {
    logic load;      // capture input sample
    logic mul;       // form coefficient product
    logic upd;       // update envelope, peak, tally, seconds
    logic div_init;  // set up the density division
    logic div_step;  // one quotient bit
    logic finish;    // load result register and clear clip state
  } cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic last;
  } status_t;

endpackage

FILE: rtl/envelope_transient_analyzer_top.sv
// ----------------------------------------------------------------------------
// envelope_transient_analyzer_top: clip envelope and transient analyzer
// Follows the attack/release envelope of an audio stream and reports punch,
// peak level and transient count at the end of each clip.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one signed Q1.15 sample per transfer, with a last flag on
//   the final sample of a clip. in_stall_o is low only while the sequencer
//   waits for a sample.
//   Each sample goes through capture, one pass through the shared
//   coefficient multiplier, then the envelope/peak/tally update; the
//   block takes no new sample until the sequencer is idle again.
//   A last sample adds a divider setup step, 44 steps of the bit-serial
//   divider (one quotient bit per cycle for tally * 2^24 / (10 * seconds))
//   and the load of the result register, which waits while a stalled
//   result is still held; out_valid_o rises with that load, and the next
//   sample can transfer after it.
//   Output channel: one result per clip. The result register holds until
//   the receiver drops out_stall_i; samples of the next clip keep flowing
//   meanwhile, and only the next clip's final load waits for the register.
//   Loading the result clears envelope, peak, tally and second counters.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//   write only while no clip sample is in flight.
//   Reset (rst_ni low, asynchronous) restores default coefficients, floor
//   and sample rate, clears all clip state and drops out_valid_o.
// ----------------------------------------------------------------------------
module envelope_transient_analyzer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [eta_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [eta_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Sample channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  eta_pkg::in_t                      in_data_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output eta_pkg::out_t                     out_data_o
);

  // Command and status between sequencer and datapath
  eta_pkg::cmd_t    cmd;
  eta_pkg::status_t status;

  // Sequencer: sample steps, divider iterations, result valid
  eta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: registers, envelope follower, divider, result register
  eta_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/eta_ctrl.sv
// ----------------------------------------------------------------------------
// eta_ctrl: sequencer of the envelope transient analyzer
// Walks each sample through multiply and update, runs the divider on the
// last sample of a clip and owns the result valid flag.
// ----------------------------------------------------------------------------
module eta_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  eta_pkg::status_t status_i,
  output eta_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DINIT,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                     state_q, state_d;
  logic [eta_pkg::STEP_W-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = status_i.last ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == eta_pkg::STEP_W'(eta_pkg::NUM_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/eta_dp.sv
// ----------------------------------------------------------------------------
// eta_dp: datapath of the envelope transient analyzer
// Configuration registers, envelope follower with one shared multiplier,
// peak and transient tracking, seconds counter, bit-serial divider and
// the result register.
// ----------------------------------------------------------------------------
module eta_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eta_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [eta_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  eta_pkg::in_t                        in_data_i,
  input  eta_pkg::cmd_t                       cmd_i,
  output eta_pkg::status_t                    status_o,
  output eta_pkg::out_t                       out_data_o
);

  localparam int ENV_W     = eta_pkg::ENV_W;
  localparam int SB        = eta_pkg::SAMPLE_BITS;
  localparam int MAG_SHIFT = ENV_W - SB;
  localparam int PROD_W    = 2 * (ENV_W + 1);
  localparam int ACC_W     = PROD_W + 1;
  localparam int NUM_W     = eta_pkg::NUM_W;
  localparam int DIV_W     = eta_pkg::DIV_W;
  localparam int CNT_W     = eta_pkg::COUNT_BITS;
  localparam int SPS_W     = eta_pkg::SPS_W;
  localparam int SECS_W    = eta_pkg::SECS_W;
  localparam int OUT_W     = eta_pkg::OUT_W;

  // Configuration
  logic [eta_pkg::COEF_W-1:0]  attack_q, release_q;
  logic [eta_pkg::FLOOR_W-1:0] floor_q;
  logic [SPS_W-1:0]            sps_q;

  // Clip state; the previous envelope is always the current one
  logic [ENV_W-1:0]  env_q, peak_q;
  logic [CNT_W-1:0]  tally_q;
  logic [SPS_W-1:0]  sis_q;
  logic [SECS_W-1:0] secs_q;

  // Payload pipeline
  logic [ENV_W-1:0]         mag_q;
  logic                     last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]         num_q;
  logic [DIV_W-1:0]         rem_q, div_q;
  eta_pkg::out_t            out_q;

  // Magnitude of the incoming sample; the most negative code maps to +1.0
  logic [SB:0]     samp_ext, samp_abs;
  logic [ENV_W-1:0] mag_new;
  assign samp_ext = {in_data_i.sample[SB-1], in_data_i.sample};
  assign samp_abs = in_data_i.sample[SB-1] ? ((SB+1)'(0) - samp_ext) : samp_ext;
  assign mag_new  = {samp_abs[SB-1:0], {MAG_SHIFT{1'b0}}};

  // env' = mag + a * (env - mag), rounded
  logic [eta_pkg::COEF_W-1:0]  coef;
  logic signed [ENV_W:0]       diff;
  logic signed [ENV_W+1:0]     coef_s;
  logic signed [ACC_W-1:0]     acc;
  logic [ENV_W-1:0]            env_new;
  assign coef    = (mag_q > env_q) ? attack_q : release_q;
  assign diff    = $signed({1'b0, env_q}) - $signed({1'b0, mag_q});
  assign coef_s  = $signed({2'b00, coef});
  assign acc     = $signed({{(ACC_W-2*ENV_W){1'b0}}, mag_q, {ENV_W{1'b0}}})
                 + ACC_W'(prod_q)
                 + $signed(ACC_W'(1) <<< (ENV_W - 1));
  assign env_new = acc[2*ENV_W-1:ENV_W];

  // Transient test: 2*env' > 3*env and env' > floor
  logic [ENV_W+1:0] env2, prev3;
  logic             is_trans;
  assign env2     = {1'b0, env_new, 1'b0};
  assign prev3    = {2'b00, env_q} + {1'b0, env_q, 1'b0};
  assign is_trans = (env2 > prev3) &&
                    (env_new > {floor_q, {(ENV_W-eta_pkg::FLOOR_W){1'b0}}});

  // Seconds
  logic [SPS_W-1:0] sps_eff;
  logic [SPS_W:0]   sis_inc;
  logic             sec_wrap;
  assign sps_eff  = (sps_q == '0) ? SPS_W'(1) : sps_q;
  assign sis_inc  = {1'b0, sis_q} + 1'b1;
  assign sec_wrap = (sis_inc >= {1'b0, sps_eff});

  // Divisor 10 * max(seconds, 1)
  logic [SECS_W-1:0] secs_eff;
  logic [DIV_W-1:0]  div_new;
  assign secs_eff = (secs_q == '0) ? SECS_W'(1) : secs_q;
  assign div_new  = (DIV_W'(secs_eff) << 3) + (DIV_W'(secs_eff) << 1);

  // Restoring divider step, quotient shifts into the numerator register
  logic [DIV_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_q});

  // Result
  logic [NUM_W:0] punch_sum;
  eta_pkg::out_t  out_new;
  always_comb begin
    punch_sum = {1'b0, num_q} + (NUM_W+1)'(peak_q);
    out_new.punch = (|punch_sum[NUM_W:OUT_W+8]) ? {OUT_W{1'b1}}
                                                : punch_sum[OUT_W+7:8];
    out_new.peak_level = peak_q[ENV_W-1] ? {OUT_W{1'b1}} : peak_q[ENV_W-2:7];
    out_new.transient_total = eta_pkg::TOTAL_W'(tally_q);
  end

  assign status_o.last = last_q;
  assign out_data_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= eta_pkg::ATTACK_RST;
      release_q <= eta_pkg::RELEASE_RST;
      floor_q   <= eta_pkg::FLOOR_RST;
      sps_q     <= eta_pkg::SPS_RST;
    end else if (cfg_we_i) begin
      unique case (eta_pkg::cfg_idx_e'(cfg_idx_i))
        eta_pkg::CFG_ATTACK:  attack_q  <= cfg_wdata_i[eta_pkg::COEF_W-1:0];
        eta_pkg::CFG_RELEASE: release_q <= cfg_wdata_i[eta_pkg::COEF_W-1:0];
        eta_pkg::CFG_FLOOR:   floor_q   <= cfg_wdata_i[eta_pkg::FLOOR_W-1:0];
        eta_pkg::CFG_SPS:     sps_q     <= cfg_wdata_i[SPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q   <= '0;
      peak_q  <= '0;
      tally_q <= '0;
      sis_q   <= '0;
      secs_q  <= '0;
    end else if (cmd_i.finish) begin
      env_q   <= '0;
      peak_q  <= '0;
      tally_q <= '0;
      sis_q   <= '0;
      secs_q  <= '0;
    end else if (cmd_i.upd) begin
      env_q <= env_new;
      if (env_new > peak_q) begin
        peak_q <= env_new;
      end
      if (is_trans && (tally_q != {CNT_W{1'b1}})) begin
        tally_q <= tally_q + 1'b1;
      end
      if (sec_wrap) begin
        sis_q <= '0;
        if (secs_q != {SECS_W{1'b1}}) begin
          secs_q <= secs_q + 1'b1;
        end
      end else begin
        sis_q <= sis_inc[SPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= mag_new;
      last_q <= in_data_i.last;
    end
    if (cmd_i.mul) begin
      prod_q <= coef_s * diff;
    end
    if (cmd_i.div_init) begin
      num_q <= {tally_q, {ENV_W{1'b0}}};
      rem_q <= '0;
      div_q <= div_new;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIV_W-1:0];
    end
    if (cmd_i.finish) begin
      out_q <= out_new;
    end
  end

endmodule

FILE: rtl/eta_checker.sv
// ----------------------------------------------------------------------------
// eta_checker: port-level checks of the envelope transient analyzer
// Watches the top-level channels and flags sequencing and result slips.
// ----------------------------------------------------------------------------
module eta_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input eta_pkg::out_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Go busy after each sample transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample accepted while previous one still in work");

  // Raise a result only at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a clip end in work");

  // Punch carries at least half the peak level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.punch} >= {2'b00, out_data_o.peak_level[15:1]}))
    else $error("punch below half of peak level");

endmodule

bind envelope_transient_analyzer_top eta_checker u_eta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: tb/envelope_transient_analyzer_top_test.sv
// ----------------------------------------------------------------------------
// envelope_transient_analyzer_top_test: self-checking bench for the analyzer
// Streams clips of audio samples into the block and keeps a cycle-free
// prediction of the envelope follower, peak and transient tally. Every clip
// summary that leaves the block is checked field by field against the
// oldest predicted summary. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module envelope_transient_analyzer_top_test;
  import eta_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 64;    // idle time after the last owed summary
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 85;
  localparam int MAX_PRINTS     = 100;

  // Prediction of one clip analyzer: configuration, clip state and the
  // summaries that are still owed by the block.
  class clip_summary_model;
    logic [COEF_W-1:0]  atk_coeff;
    logic [COEF_W-1:0]  rel_coeff;
    logic [FLOOR_W-1:0] floor_lvl;
    logic [SPS_W-1:0]   rate;
    longint unsigned    env, prev_env, peak_env, tally, in_second, seconds;
    out_t               summaries_due[$];
    int                 failures;

    function new();
      atk_coeff = ATTACK_RST;
      rel_coeff = RELEASE_RST;
      floor_lvl = FLOOR_RST;
      rate      = SPS_RST;
      failures  = 0;
      clear_clip();
    endfunction

    function void clear_clip();
      env       = 0;
      prev_env  = 0;
      peak_env  = 0;
      tally     = 0;
      in_second = 0;
      seconds   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ATTACK:  atk_coeff = data[COEF_W-1:0];
        CFG_RELEASE: rel_coeff = data[COEF_W-1:0];
        CFG_FLOOR:   floor_lvl = data[FLOOR_W-1:0];
        CFG_SPS:     rate      = data[SPS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return summaries_due.size();
    endfunction

    // Advance the clip by one sample; on the last sample queue its summary.
    function void take_sample(in_t item);
      int              sv;
      longint unsigned mag, coef, acc, floor_env, rate_eff, secs, dens, punch, level;
      out_t            res;
      sv = item.sample;
      if (sv < 0) sv = -sv;  // most negative sample maps to +1.0
      mag = sv;
      mag = mag << (ENV_W - SAMPLE_BITS);
      coef = (mag > env) ? atk_coeff : rel_coeff;
      acc = coef * env + ((64'd1 << COEF_W) - coef) * mag + (64'd1 << (ENV_W - 1));
      env = (acc >> COEF_W) & ((64'd1 << ENV_W) - 1);
      if (env > peak_env) peak_env = env;
      floor_env = floor_lvl;
      floor_env = floor_env << 8;
      if (env * 2 > prev_env * 3 && env > floor_env && tally < (64'd1 << COUNT_BITS) - 1)
        tally++;
      prev_env = env;

      // Close a second once the count reaches the rate; zero rate acts as one.
      rate_eff = (rate == 0) ? 1 : rate;
      in_second++;
      if (in_second >= rate_eff) begin
        in_second = 0;
        if (seconds < 65535) seconds++;
      end
      if (!item.last) return;

      secs  = (seconds == 0) ? 1 : seconds;  // short clips count as one second
      dens  = (tally << ENV_W) / (10 * secs);
      punch = (dens + peak_env) >> 8;
      level = peak_env >> 7;
      if (punch > 65535) punch = 65535;
      if (level > 65535) level = 65535;
      res.punch           = OUT_W'(punch);
      res.peak_level      = OUT_W'(level);
      res.transient_total = TOTAL_W'(tally);
      summaries_due.push_back(res);
      clear_clip();
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        failures++;
        if (failures <= MAX_PRINTS)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_summary(out_t got);
      out_t want;
      if (summaries_due.size() == 0) begin
        failures++;
        if (failures <= MAX_PRINTS)
          $display("%0t: unexpected summary: expected none, actual %0d/%0d/%0d", $time,
                   got.punch, got.peak_level, got.transient_total);
        return;
      end
      want = summaries_due.pop_front();
      compare_field("punch", want.punch, got.punch);
      compare_field("peak_level", want.peak_level, got.peak_level);
      compare_field("transient_total", want.transient_total, got.transient_total);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;

  clip_summary_model summaries;
  bit                bursts_on = 1'b0;  // random idling on both channels
  int                stuck_cycles = 0;

  envelope_transient_analyzer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sample every transfer at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) summaries.write_reg(cfg_idx, cfg_wdata);
      if (in_valid && !in_stall) summaries.take_sample(in_data);
      if (out_valid && !out_stall) summaries.check_summary(out_data);
    end
  end

  // Count cycles in which nothing moves; a hang shows up as a long stretch.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Receiver: stall in random bursts while bursts are enabled, and let a
  // running burst run out on its own.
  initial begin
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall = 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        hold      = $urandom_range(0, 15);
      end
    end
  end

  // Offer one sample and hold it until the block takes the transfer.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] value, logic last);
    int gap;
    gap = (bursts_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data.sample = value;
    in_data.last   = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every owed summary, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (summaries.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic program_regs(logic [COEF_W-1:0] atk, logic [COEF_W-1:0] rel,
                              logic [FLOOR_W-1:0] flr, logic [SPS_W-1:0] sps);
    write_cfg(CFG_ATTACK, atk);
    write_cfg(CFG_RELEASE, rel);
    write_cfg(CFG_FLOOR, flr);
    write_cfg(CFG_SPS, sps);
  endtask

  // Pick a setting per phase, biased toward fast attack, small floors and low
  // rates so that transients and whole seconds actually occur.
  task automatic program_random();
    logic [COEF_W-1:0]  atk, rel;
    logic [FLOOR_W-1:0] flr;
    logic [SPS_W-1:0]   sps;
    case ($urandom_range(0, 4))
      0:       atk = '0;
      1:       atk = '1;
      2, 3:    atk = $urandom_range(0, 24'h100000);
      default: atk = $urandom_range(0, 24'hFFFFFF);
    endcase
    case ($urandom_range(0, 4))
      0:       rel = '0;
      1:       rel = '1;
      2, 3:    rel = $urandom_range(24'hF00000, 24'hFFFFFF);
      default: rel = $urandom_range(0, 24'hFFFFFF);
    endcase
    case ($urandom_range(0, 4))
      0:       flr = '0;
      1:       flr = 16'd32768;
      2, 3:    flr = $urandom_range(0, 4096);
      default: flr = $urandom_range(0, 32768);
    endcase
    case ($urandom_range(0, 4))
      0:       sps = 18'd1;
      1:       sps = 18'd192000;
      2, 3:    sps = $urandom_range(1, 40);
      default: sps = $urandom_range(1, 192000);
    endcase
    program_regs(atk, rel, flr, sps);
  endtask

  // Sample shapes: full-range noise, quiet/loud bursts, low level, extremes.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int style, int k);
    case (style)
      0: return SAMPLE_BITS'($urandom);
      1: begin
        if (k % 8 < 5) return SAMPLE_BITS'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) return SAMPLE_BITS'($urandom_range(16384, 32767));
        return SAMPLE_BITS'(-$urandom_range(16384, 32768));
      end
      2: return SAMPLE_BITS'($urandom_range(0, 1023)) - SAMPLE_BITS'(512);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    int sent, len, style;
    bit open_end;

    summaries = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_ATTACK;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default setting: both sample extremes, minus one, plus one, zero.
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    settle();

    // Instant attack, frozen release, no floor, one sample per second.
    program_regs('0, '1, '0, 18'd1);
    send_sample(16'd100, 1'b0);
    send_sample(16'd200, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    settle();

    // Frozen attack, instant release, top floor, top rate.
    program_regs('1, '0, 16'd32768, 18'd192000);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd5, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    settle();

    // Zero rate acts as one sample per second; each step is a transient.
    program_regs('0, '0, '0, '0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd4000, 1'b1);
    settle();

    // Lower the rate in the middle of a clip that has passed the new value.
    write_cfg(CFG_SPS, 18'd192000);
    for (int k = 0; k < 5; k++) send_sample(SAMPLE_BITS'(1000 * (k + 1)), 1'b0);
    settle();
    write_cfg(CFG_SPS, 18'd2);
    for (int k = 0; k < 3; k++) send_sample(SAMPLE_BITS'(7000 * (k + 1)), k == 2);
    settle();

    // Random phases; a clip may stay open across a setting change. The last
    // phase runs without idling and always closes its clip.
    for (int ph = 0; ph < PHASES; ph++) begin
      program_random();
      bursts_on = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len      = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 30);
        style    = $urandom_range(0, 3);
        open_end = (sent + len >= PHASE_ITEMS) && (ph < PHASES - 1) &&
                   ($urandom_range(0, 2) == 0);
        for (int k = 0; k < len; k++)
          send_sample(pick_sample(style, k), (k == len - 1) && !open_end);
        sent += len;
      end
      bursts_on = 1'b0;
      settle();
    end

    if (summaries.failures == 0 && summaries.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
